@@ hdl/scs_pkg.sv @@
// Shared types, constants and helpers for the sound command sequencer.
package scs_pkg;

	// Command queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

	// Field widths and fixed levels
	localparam int CMD_W      = 5;
	localparam int HOLD_W     = 16;
	localparam int PORT_W     = 8;
	localparam int SND16_BIT  = 4;
	localparam logic [PORT_W-1:0] PORT_RELEASE = 8'h7f;
	localparam logic [HOLD_W-1:0] HOLD_MAX     = 16'hffff;
	localparam logic [HOLD_W-1:0] HOLD_RESET   = 16'd50;

	// Operation codes
	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Playback stages
	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_SND16   = 3'd1,
		ST_PORT    = 3'd2,
		ST_HOLD    = 3'd3,
		ST_CLEAR16 = 3'd4,
		ST_RELEASE = 3'd5
	} stage_t;

	typedef struct packed {
		logic             operation;
		logic [CMD_W-1:0] command;
	} item_t;

	typedef struct packed {
		logic [PORT_W-1:0] sound_port;
		logic              snd16_line;
		logic              dropped;
		logic              busy_res;
	} result_t;

	// Queue control from the sequencer and status back to it
	typedef struct packed {
		logic push;
		logic pop;
	} queue_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} queue_stat_t;

	// Advance a queue pointer with wrap at any depth
	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

endpackage

@@ hdl/scs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module scs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// Registered read port, hold data when not reading
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

@@ hdl/scs_queue.sv @@
// Command FIFO: pointer and fill control around the queue RAM.
module scs_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  scs_pkg::queue_ctl_t       ctl,
	input  logic [scs_pkg::CMD_W-1:0] push_data,
	output scs_pkg::queue_stat_t      stat,
	output logic [scs_pkg::CMD_W-1:0] pop_data
);
	import scs_pkg::*;

	logic [QPTR_W-1:0]  head_q;
	logic [QPTR_W-1:0]  tail_q;
	logic [QFILL_W-1:0] fill_q;

	assign stat.empty = (fill_q == '0);
	assign stat.full  = (fill_q == QFILL_W'(QUEUE_DEPTH));

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			if (ctl.push)
				tail_q <= ptr_next(tail_q);
			if (ctl.pop)
				head_q <= ptr_next(head_q);
			if (ctl.push && !ctl.pop)
				fill_q <= fill_q + 1'b1;
			else if (ctl.pop && !ctl.push)
				fill_q <= fill_q - 1'b1;
		end
	end

	// Entry at head is read on pop; data shows the cycle after
	scs_ram #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ctl.push),
		.waddr(tail_q),
		.wdata(push_data),
		.re   (ctl.pop),
		.raddr(head_q),
		.rdata(pop_data)
	);

endmodule

@@ hdl/sound_command_sequencer_top.sv @@
// Top level: command queue, playback sequencer and result register.
//
// Usage:
//   item channel (item_valid/item_ready/item) carries one transaction per
//   command push (operation 0) or millisecond tick (operation 1).
//   result channel (result_valid/result_ready/result) returns exactly one
//   transaction per item: port byte, snd16 level, drop flag, busy flag.
//   cfg channel (cfg_valid/cfg_ready/cfg_data), always ready, writes
//   hold_ticks; the user must write it while the block is idle (not enforced).
// Result: the result of an item is registered and valid in the cycle after acceptance.
// Throughput: one item per cycle unless a held result stalls; the next
//   sequencer state is combinational and the queue RAM takes one write or
//   one read per cycle, the popped command forwarded from its read register.
// Reset: queue empty, stage idle, port 0x7f, snd16 low, hold_ticks 50.
//   The queue RAM needs no clearing; only written entries are read.
// Stall: a held result blocks new items only while it is not taken;
//   item_ready follows result_ready in the same cycle.
module sound_command_sequencer_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_ready,
	input  scs_pkg::item_t             item,
	output logic                       result_valid,
	input  logic                       result_ready,
	output scs_pkg::result_t           result,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [scs_pkg::HOLD_W-1:0] cfg_data
);
	import scs_pkg::*;

	logic [HOLD_W-1:0] hold_ticks_q;
	stage_t            stage_q, stage_n;
	logic [CMD_W-1:0]  cur_q, cur;
	logic [HOLD_W-1:0] hold_q, hold_n, hold_inc;
	logic [PORT_W-1:0] port_q, port_n;
	logic              snd16_q, snd16_n;
	logic              pop_s1;
	logic              accept, tick, push_req, dropped;
	queue_ctl_t        qctl;
	queue_stat_t       qstat;
	logic [CMD_W-1:0]  pop_data;
	result_t           result_q;
	logic              result_valid_q;

	assign accept     = item_valid && item_ready;
	assign tick       = accept && (item.operation == OP_TICK);
	assign push_req   = accept && (item.operation == OP_PUSH);
	assign dropped    = push_req && qstat.full;
	assign item_ready = !result_valid_q || result_ready;
	assign cfg_ready  = 1'b1;

	// Forward the popped command straight from the RAM read register
	assign cur      = pop_s1 ? pop_data : cur_q;
	assign hold_inc = (hold_q != HOLD_MAX) ? hold_q + 1'b1 : hold_q;

	// Queue push on a push item; next stage and levels on a tick
	always_comb begin
		stage_n   = stage_q;
		hold_n    = hold_q;
		port_n    = port_q;
		snd16_n   = snd16_q;
		qctl.push = push_req && !qstat.full;
		qctl.pop  = 1'b0;
		if (tick) begin
			case (stage_q)
				ST_IDLE: begin
					if (!qstat.empty) begin
						qctl.pop = 1'b1;
						stage_n  = ST_SND16;
					end
				end
				ST_SND16: begin
					snd16_n = cur[SND16_BIT];
					stage_n = ST_PORT;
				end
				ST_PORT: begin
					port_n  = ~{{(PORT_W - CMD_W){1'b0}}, cur};
					hold_n  = '0;
					stage_n = ST_HOLD;
				end
				ST_HOLD: begin
					hold_n = hold_inc;
					if (hold_inc >= hold_ticks_q)
						stage_n = cur[SND16_BIT] ? ST_CLEAR16 : ST_RELEASE;
				end
				ST_CLEAR16: begin
					snd16_n = 1'b0;
					stage_n = ST_RELEASE;
				end
				ST_RELEASE: begin
					port_n  = PORT_RELEASE;
					stage_n = ST_IDLE;
				end
				default: begin
					stage_n = ST_IDLE;
				end
			endcase
		end
	end

	scs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (qctl),
		.push_data(item.command),
		.stat     (qstat),
		.pop_data (pop_data)
	);

	// Sequencer state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= HOLD_RESET;
			stage_q      <= ST_IDLE;
			cur_q        <= '0;
			hold_q       <= '0;
			port_q       <= PORT_RELEASE;
			snd16_q      <= 1'b0;
			pop_s1       <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				hold_ticks_q <= cfg_data;
			stage_q <= stage_n;
			cur_q   <= cur;
			hold_q  <= hold_n;
			port_q  <= port_n;
			snd16_q <= snd16_n;
			pop_s1  <= qctl.pop;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (item_ready)
			result_valid_q <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.sound_port <= port_n;
			result_q.snd16_line <= snd16_n;
			result_q.dropped    <= dropped;
			result_q.busy_res   <= (stage_n != ST_IDLE);
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

@@ hdl/scs_checker.sv @@
// Port-level checks for the sound command sequencer, bound to the top level.
module scs_port_checks (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       item_valid,
	input logic                       item_ready,
	input scs_pkg::item_t             item,
	input logic                       result_valid,
	input logic                       result_ready,
	input scs_pkg::result_t           result
);
	import scs_pkg::*;

	// Stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Every accepted item yields a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> result_valid)
		else $error("no result after accepted item");

	// A tick never reports a drop
	a_tick_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item.operation == OP_TICK |=> !result.dropped)
		else $error("drop flagged on tick");

	// Idle means released port and snd16 low
	a_idle_levels: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.busy_res |->
			result.sound_port == PORT_RELEASE && !result.snd16_line)
		else $error("idle with sound still driven");

endmodule

bind sound_command_sequencer_top scs_port_checks u_scs_checker (.*);
